>>> rtl/pol_pkg.sv
// Package of request codes, status codes and controller/datapath types for the ordered list.
package pol_pkg;

  localparam int ReqW = 3;
  localparam int PosW = 6;
  localparam int ValW = 32;
  localparam int StW  = 2;

  localparam logic [ReqW-1:0] REQ_ADD_FRONT = 3'd0;
  localparam logic [ReqW-1:0] REQ_ADD_END   = 3'd1;
  localparam logic [ReqW-1:0] REQ_DEL_FRONT = 3'd2;
  localparam logic [ReqW-1:0] REQ_DEL_END   = 3'd3;
  localparam logic [ReqW-1:0] REQ_INS_AT    = 3'd4;
  localparam logic [ReqW-1:0] REQ_DEL_AT    = 3'd5;
  localparam logic [ReqW-1:0] REQ_TRAVERSE  = 3'd6;

  localparam logic [StW-1:0] ST_OK     = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StW-1:0] ST_BADPOS = 2'd2;
  localparam logic [StW-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic exec;
    logic trav_step;
  } pol_cmd_t;

  typedef struct packed {
    logic trav_go;
    logic trav_last;
  } pol_stat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TRAV = 2'b10
  } pol_state_t;

endpackage

>>> rtl/pol_ctrl.sv
// Controller state machine that accepts requests and paces traversal.
module pol_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pol_pkg::pol_stat_t stat,
  output pol_pkg::pol_cmd_t  cmd,
  output logic              busy
);
  import pol_pkg::*;

  pol_state_t state, state_next;

  always_comb begin
    state_next    = state;
    cmd.exec      = 1'b0;
    cmd.trav_step = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.exec = start;
        if (start && stat.trav_go) state_next = S_TRAV;
      end
      S_TRAV: begin
        cmd.trav_step = 1'b1;
        if (stat.trav_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state == S_TRAV);

  a_busy_no_exec: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.exec) else $error("request taken while traversing");
  a_trav_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.trav_step && stat.trav_last) |=> !busy) else $error("traversal did not end");
  a_trav_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && stat.trav_go) |=> busy) else $error("traversal did not start");

endmodule

>>> rtl/pol_dp.sv
// Datapath: shifting cell array, entry count, traversal index and result registers.
module pol_dp #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pol_pkg::pol_cmd_t           cmd,
  output pol_pkg::pol_stat_t          stat,
  input  logic [pol_pkg::ReqW-1:0]    req_type,
  input  logic [pol_pkg::PosW-1:0]    position,
  input  logic signed [pol_pkg::ValW-1:0] value_in,
  output logic [pol_pkg::StW-1:0]     status,
  output logic signed [pol_pkg::ValW-1:0] value_out,
  output logic                        last_result,
  output logic                        strobe
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > PosW) ? CW : PosW) + 1;

  logic signed [ValW-1:0] cells [CAPACITY];
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] tidx;

  logic [PW-1:0] pos_x, cnt_x, idx;
  logic          full, empty, do_ins, do_del;
  logic          trav_go, trav_last;
  logic [StW-1:0] dec_status;

  assign pos_x = PW'(position);
  assign cnt_x = PW'(count);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    idx        = '0;
    dec_status = ST_OK;
    trav_go    = 1'b0;
    case (req_type)
      REQ_ADD_FRONT, REQ_ADD_END: begin
        if (full) dec_status = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx    = (req_type == REQ_ADD_FRONT) ? '0 : cnt_x;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_END: begin
        if (empty) dec_status = ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx    = (req_type == REQ_DEL_FRONT) ? '0 : cnt_x - PW'(1);
        end
      end
      REQ_INS_AT: begin
        if (pos_x == '0 || pos_x > cnt_x + PW'(1)) dec_status = ST_BADPOS;
        else if (full) dec_status = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx    = pos_x - PW'(1);
        end
      end
      REQ_DEL_AT: begin
        if (empty) dec_status = ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) dec_status = ST_BADPOS;
        else begin
          do_del = 1'b1;
          idx    = pos_x - PW'(1);
        end
      end
      REQ_TRAVERSE: begin
        if (empty) dec_status = ST_EMPTY;
        else trav_go = 1'b1;
      end
      default: dec_status = ST_OK;
    endcase
  end

  assign trav_last = (CW'(tidx) == count - CW'(1));
  assign stat = '{trav_go: trav_go, trav_last: trav_last};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec && do_ins) begin
        if (PW'(i) == idx) cells[i] <= value_in;
        else if (PW'(i) > idx) begin
          if (i > 0) cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.exec && do_del) begin
        if (PW'(i) >= idx && i < CAPACITY - 1) begin
          cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.exec && do_ins) count_next = count + CW'(1);
    else if (cmd.exec && do_del) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      tidx   <= '0;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= (cmd.exec && !trav_go) || cmd.trav_step;
      if (cmd.exec) tidx <= '0;
      else if (cmd.trav_step) tidx <= tidx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trav_step) begin
      status      <= ST_OK;
      value_out   <= cells[tidx];
      last_result <= trav_last;
    end else if (cmd.exec) begin
      status      <= dec_status;
      value_out   <= '0;
      last_result <= 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("entry count beyond capacity");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(count)) else $error("entry count changed without a request");
  a_trav_word: assert property (@(posedge clk) disable iff (rst)
    cmd.trav_step |=> (strobe && status == ST_OK)) else $error("traversal word missing");

endmodule

>>> rtl/positional_ordered_list.sv
// Top level of the ordered list: joins the controller and the datapath.
//
// Channel   Direction  Handshake               Word
// request   in         start high, busy low    req_type, position, value_in
// result    out        strobe, one cycle       status, value_out, last_result
//
// A request that is not a traversal is taken when start is high and busy low; its single result
// word appears on the cycle after; the next request may be taken at once.
// A traversal of N entries holds busy until its last entry is read, one word per cycle read
// from the cell array by the traversal index.
// Reset empties the list; stored values are not cleared.
// The receiver cannot stall: every strobed word is taken in its cycle.
module positional_ordered_list_core #(
  parameter int CAPACITY = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [pol_pkg::ReqW-1:0]        req_type,
  input  logic [pol_pkg::PosW-1:0]        position,
  input  logic signed [pol_pkg::ValW-1:0] value_in,
  output logic                            strobe,
  output logic [pol_pkg::StW-1:0]         status,
  output logic signed [pol_pkg::ValW-1:0] value_out,
  output logic                            last_result
);
  import pol_pkg::*;

  pol_cmd_t  cmd;
  pol_stat_t stat;

  pol_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pol_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .position    (position),
    .value_in    (value_in),
    .status      (status),
    .value_out   (value_out),
    .last_result (last_result),
    .strobe      (strobe)
  );

endmodule

>>> test/positional_ordered_list_core_tb.sv
// Self-checking testbench for the ordered list core, with a scoreboard that predicts every result word.
`timescale 1ns / 1ps

module positional_ordered_list_core_tb;
  import pol_pkg::*;

  localparam int Capacity = 32;
  localparam int RandomItems = 88;
  localparam int QuietTail = 30;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 8;
  localparam int MaxPrinted = 40;
  localparam logic [ReqW-1:0] REQ_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic signed [ValW-1:0] value;
    logic                   last;
  } list_word_t;

  class ordered_list_scoreboard;
    logic signed [ValW-1:0] contents[$];
    list_word_t             expected_words[$];
    int                     errors;
    int                     requests;
    int                     words_checked;
    int                     full_hits;
    int                     traversals;

    function new();
      errors = 0;
      requests = 0;
      words_checked = 0;
      full_hits = 0;
      traversals = 0;
    endfunction

    task report_mismatch(input string msg);
      if (errors < MaxPrinted) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      errors++;
    endtask

    function void push_word(input logic [StW-1:0] st, input logic signed [ValW-1:0] v,
                            input logic last);
      list_word_t w;
      w.status = st;
      w.value = v;
      w.last = last;
      expected_words.push_back(w);
      if (st == ST_FULL) begin
        full_hits++;
      end
    endfunction

    function void note_request(input logic [ReqW-1:0] req, input logic [PosW-1:0] pos,
                               input logic signed [ValW-1:0] v);
      int cnt;
      int p;
      cnt = contents.size();
      p = int'(pos);
      requests++;
      case (req)
        REQ_ADD_FRONT, REQ_ADD_END: begin
          if (cnt >= Capacity) begin
            push_word(ST_FULL, '0, 1'b1);
          end else begin
            if (req == REQ_ADD_FRONT) begin
              contents.push_front(v);
            end else begin
              contents.push_back(v);
            end
            push_word(ST_OK, '0, 1'b1);
          end
        end
        REQ_DEL_FRONT, REQ_DEL_END: begin
          if (cnt == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else begin
            if (req == REQ_DEL_FRONT) begin
              void'(contents.pop_front());
            end else begin
              void'(contents.pop_back());
            end
            push_word(ST_OK, '0, 1'b1);
          end
        end
        REQ_INS_AT: begin
          if (p < 1 || p > cnt + 1) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else if (cnt >= Capacity) begin
            push_word(ST_FULL, '0, 1'b1);
          end else begin
            contents.insert(p - 1, v);
            push_word(ST_OK, '0, 1'b1);
          end
        end
        REQ_DEL_AT: begin
          if (cnt == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else if (p < 1 || p > cnt) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else begin
            contents.delete(p - 1);
            push_word(ST_OK, '0, 1'b1);
          end
        end
        REQ_TRAVERSE: begin
          traversals++;
          if (cnt == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int k = 0; k < cnt; k++) begin
              push_word(ST_OK, contents[k], k == cnt - 1);
            end
          end
        end
        default: begin
          push_word(ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    task check_result(input logic [StW-1:0] st, input logic signed [ValW-1:0] v,
                      input logic last);
      list_word_t w;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word with nothing outstanding (status %0d)", st));
      end else begin
        w = expected_words.pop_front();
        words_checked++;
        if (st !== w.status) begin
          report_mismatch($sformatf("status %0d, predicted %0d", st, w.status));
        end
        if (v !== w.value) begin
          report_mismatch($sformatf("value_out %0d, predicted %0d", v, w.value));
        end
        if (last !== w.last) begin
          report_mismatch($sformatf("last_result %0b, predicted %0b", last, w.last));
        end
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    function int list_size();
      return contents.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [ReqW-1:0]        req_type;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] value_in;
  logic                   strobe;
  logic [StW-1:0]         status;
  logic signed [ValW-1:0] value_out;
  logic                   last_result;

  ordered_list_scoreboard sb = new();
  int stall_cycles = 0;
  bit shrinking = 1'b0;

  positional_ordered_list_core #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .position(position),
    .value_in(value_in),
    .strobe(strobe),
    .status(status),
    .value_out(value_out),
    .last_result(last_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_result(status, value_out, last_result);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Timeout: nothing accepted for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task send_request(input logic [ReqW-1:0] r, input logic [PosW-1:0] p,
                    input logic signed [ValW-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    req_type <= r;
    position <= p;
    value_in <= v;
    do begin
      @(posedge clk);
    end while (busy);
    sb.note_request(r, p, v);
  endtask

  task idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Positions are mostly valid for the current size; the rest fall below or above the range.
  function logic [PosW-1:0] pick_position(input int top);
    if (top >= 1 && $urandom_range(0, 4) != 0) begin
      return PosW'($urandom_range(1, top));
    end else if (top + 1 <= 63 && $urandom_range(0, 1) == 0) begin
      return PosW'($urandom_range(top + 1, 63));
    end else begin
      return '0;
    end
  endfunction

  task random_request();
    int cnt;
    int pick;
    logic [ReqW-1:0] r;
    cnt = sb.list_size();
    if (cnt == 0) begin
      shrinking = 1'b0;
    end else if (cnt == Capacity && $urandom_range(0, 2) == 0) begin
      shrinking = 1'b1;
    end
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      if (shrinking) begin
        r = REQ_DEL_FRONT + ReqW'($urandom_range(0, 1));
        if (pick < 5) begin
          r = REQ_DEL_AT;
        end
      end else begin
        r = ReqW'($urandom_range(0, 1));
        if (pick < 6) begin
          r = REQ_INS_AT;
        end
      end
    end else if (pick < 17) begin
      r = REQ_TRAVERSE;
    end else begin
      r = ReqW'($urandom_range(0, 7));
    end
    send_request(r, pick_position(r == REQ_INS_AT ? cnt + 1 : cnt), pick_value());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = '0;
    position = '0;
    value_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty-list errors and position checks on an empty list.
    send_request(REQ_TRAVERSE, '0, '0);
    send_request(REQ_DEL_FRONT, '0, '0);
    send_request(REQ_DEL_END, '1, '0);
    send_request(REQ_DEL_AT, '0, '0);
    send_request(REQ_DEL_AT, 6'd1, '0);
    send_request(REQ_INS_AT, '0, 32'sd5);
    send_request(REQ_INS_AT, 6'd2, 32'sd6);
    idle_cycles(3);
    send_request(REQ_INS_AT, 6'd1, 32'sh7fff_ffff);
    send_request(REQ_ADD_FRONT, '0, 32'sh8000_0000);
    send_request(REQ_ADD_END, '1, 32'sd0);
    send_request(REQ_ADD_END, '0, -32'sd1);
    send_request(REQ_INS_AT, 6'd5, 32'sh5555_aaaa);
    send_request(REQ_TRAVERSE, '1, '1);
    send_request(REQ_INS_AT, 6'd63, 32'sd7);
    send_request(REQ_DEL_AT, '0, '0);
    send_request(REQ_DEL_AT, 6'd63, '0);
    send_request(REQ_DEL_AT, 6'd2, '0);
    send_request(REQ_UNKNOWN, 6'd63, 32'shffff_ffff);
    idle_cycles(2);
    send_request(REQ_TRAVERSE, '0, '0);
    send_request(REQ_DEL_FRONT, '0, '0);
    send_request(REQ_DEL_END, '0, '0);
    send_request(REQ_TRAVERSE, '0, '0);

    for (int i = 0; i < RandomItems; i++) begin
      random_request();
      if (i < RandomItems - QuietTail && $urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 8));
      end
    end
    idle_cycles(1);

    while (sb.pending() > 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d requests, %0d of them traversals; checked %0d result words.",
             sb.requests, sb.traversals, sb.words_checked);
    $display("The full-list error was met %0d times.", sb.full_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pol_pkg.sv
rtl/pol_ctrl.sv
rtl/pol_dp.sv
rtl/positional_ordered_list.sv
test/positional_ordered_list_core_tb.sv
